@@ sv/pwdz_pkg.sv @@
package pwdz_pkg;

  // Q8.16 field widths
  localparam int Q_W    = 24;
  localparam int MAG_W  = 23;
  localparam int PROD_W = 49;   // 25 x 24 signed product
  localparam int ACC_W  = 36;   // P + I + D + feedforward never exceeds 2^33

  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_VELOCITY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DECEL_ZONE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OUT        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ACC_OUT    = 3'd7;

  localparam logic [MAG_W-1:0] MAX_OUT_RST = 23'h7FFFFF;

  // one degree in Q8.16 radians
  localparam logic [Q_W-1:0] INTEG_WINDOW = 24'd1144;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_WAIT      = 4'd0;
  localparam step_t STEP_INTEG     = 4'd1;
  localparam step_t STEP_MUL_P     = 4'd2;
  localparam step_t STEP_MUL_I     = 4'd3;
  localparam step_t STEP_MUL_D     = 4'd4;
  localparam step_t STEP_MUL_ZONE  = 4'd5;
  localparam step_t STEP_DIV_INIT  = 4'd6;
  localparam step_t STEP_DIV_ITER  = 4'd7;
  localparam step_t STEP_LIM_FLOOR = 4'd8;
  localparam step_t STEP_ZCLAMP    = 4'd9;
  localparam step_t STEP_MUL_V     = 4'd10;
  localparam step_t STEP_ADD_V     = 4'd11;
  localparam step_t STEP_FINAL     = 4'd12;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_EP,
    MUL_IG,
    MUL_DG,
    MUL_ZM,
    MUL_VG
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_ADD,
    ACC_CLAMP
  } acc_op_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_NO_ACC,
    COND_ZONE_OFF,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic     in_rdy;
    logic     integ_upd;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     div_init;
    logic     div_step;
    logic     lim_floor;
    logic     out_load;
    cond_t    cond;
    step_t    target;
    logic     last;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic zone_off;
    logic div_more;
    logic out_busy;
  } stat_t;

endpackage

@@ sv/pwdz_in_if.sv @@
interface pwdz_in_if import pwdz_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] error;
  logic signed [Q_W-1:0] velocity;

  modport source(output valid, output error, output velocity, input ready);
  modport sink(input valid, input error, input velocity, output ready);
endinterface

@@ sv/pwdz_out_if.sv @@
interface pwdz_out_if import pwdz_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] drive;

  modport source(output valid, output drive, input ready);
  modport sink(input valid, input drive, output ready);
endinterface

@@ sv/pwdz_seq.sv @@
module pwdz_seq import pwdz_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctrl_t ctrl
);

  step_t pc_r, pc_nxt;
  logic  take;

  // control store
  always_comb begin
    ctrl = '0;
    unique case (pc_r)
      STEP_WAIT: begin
        ctrl.in_rdy = 1'b1;
        ctrl.cond   = COND_NO_ACC;
        ctrl.target = STEP_WAIT;
      end
      STEP_INTEG: begin
        ctrl.integ_upd = 1'b1;
      end
      STEP_MUL_P: begin
        ctrl.mul_sel = MUL_EP;
        ctrl.acc_op  = ACC_CLEAR;
      end
      STEP_MUL_I: begin
        ctrl.mul_sel = MUL_IG;
        ctrl.acc_op  = ACC_ADD;
      end
      STEP_MUL_D: begin
        ctrl.mul_sel = MUL_DG;
        ctrl.acc_op  = ACC_ADD;
      end
      STEP_MUL_ZONE: begin
        ctrl.mul_sel = MUL_ZM;
        ctrl.acc_op  = ACC_ADD;
        ctrl.cond    = COND_ZONE_OFF;
        ctrl.target  = STEP_MUL_V;
      end
      STEP_DIV_INIT: begin
        ctrl.div_init = 1'b1;
      end
      STEP_DIV_ITER: begin
        ctrl.div_step = 1'b1;
        ctrl.cond     = COND_DIV_MORE;
        ctrl.target   = STEP_DIV_ITER;
      end
      STEP_LIM_FLOOR: begin
        ctrl.lim_floor = 1'b1;
      end
      STEP_ZCLAMP: begin
        ctrl.acc_op = ACC_CLAMP;
      end
      STEP_MUL_V: begin
        ctrl.mul_sel = MUL_VG;
      end
      STEP_ADD_V: begin
        ctrl.acc_op = ACC_ADD;
      end
      STEP_FINAL: begin
        ctrl.out_load = 1'b1;
        ctrl.cond     = COND_OUT_BUSY;
        ctrl.target   = STEP_FINAL;
        ctrl.last     = 1'b1;
      end
      default: begin
        ctrl.last = 1'b1;
      end
    endcase
  end

  always_comb begin
    unique case (ctrl.cond)
      COND_NONE:     take = 1'b0;
      COND_NO_ACC:   take = !stat.accept;
      COND_ZONE_OFF: take = stat.zone_off;
      COND_DIV_MORE: take = stat.div_more;
      COND_OUT_BUSY: take = stat.out_busy;
      default:       take = 1'b0;
    endcase
  end

  always_comb begin
    if (take) begin
      pc_nxt = ctrl.target;
    end else if (ctrl.last) begin
      pc_nxt = STEP_WAIT;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

@@ sv/pwdz_dp.sv @@
module pwdz_dp import pwdz_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_t                 ctrl,
  input  logic                  in_acc,
  input  logic signed [Q_W-1:0] in_error,
  input  logic signed [Q_W-1:0] in_velocity,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [Q_W-1:0]        cfg_data,
  output logic                  zone_off,
  output logic                  div_more,
  output logic signed [Q_W-1:0] drive_val
);

  localparam int RND_SH    = 16;
  localparam int TERM_W    = PROD_W - RND_SH;
  localparam int DIV_BITS  = MAG_W;
  localparam int DIV_CNT_W = $clog2(DIV_BITS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_BITS - 1);
  localparam logic signed [PROD_W-1:0] RND_UP = PROD_W'(1 << (RND_SH - 1));
  localparam logic signed [PROD_W-1:0] RND_DN = PROD_W'((1 << (RND_SH - 1)) - 1);

  // configuration
  logic signed [Q_W-1:0] gp_r, gi_r, gd_r, gv_r;
  logic [MAG_W-1:0]      ilim_r, dz_r, mo_r, mina_r;

  // loop state
  logic signed [Q_W-1:0] integ_r, integ_nxt;
  logic signed [Q_W-1:0] prev_r;
  logic                  have_prev_r;

  // working registers
  logic signed [Q_W-1:0]  e_r, v_r;
  logic [Q_W-1:0]         emag_r, emag_in;
  logic signed [Q_W:0]    deriv_r, deriv_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic [MAG_W-1:0]       rem_r, rem_nxt;
  logic [MAG_W-1:0]       sh_r, sh_nxt;
  logic [DIV_CNT_W-1:0]   div_cnt_r;
  logic [MAG_W-1:0]       lim_r;

  logic signed [Q_W:0]    isum, ilim_s, iclamp;
  logic signed [Q_W:0]    op_a;
  logic signed [Q_W-1:0]  op_b;
  logic signed [PROD_W-1:0] rsum;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  term_ext, lim_ext, mo_ext;
  logic [Q_W-1:0]         trial;
  logic                   ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gp_r   <= '0;
      gi_r   <= '0;
      gd_r   <= '0;
      gv_r   <= '0;
      ilim_r <= '0;
      dz_r   <= '0;
      mo_r   <= MAX_OUT_RST;
      mina_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_PROP:      gp_r   <= cfg_data;
        REG_GAIN_INTEG:     gi_r   <= cfg_data;
        REG_GAIN_DERIV:     gd_r   <= cfg_data;
        REG_GAIN_VELOCITY:  gv_r   <= cfg_data;
        REG_INTEGRAL_LIMIT: ilim_r <= cfg_data[MAG_W-1:0];
        REG_DECEL_ZONE:     dz_r   <= cfg_data[MAG_W-1:0];
        REG_MAX_OUT:        mo_r   <= cfg_data[MAG_W-1:0];
        REG_MIN_ACC_OUT:    mina_r <= cfg_data[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  assign emag_in = in_error[Q_W-1] ? (~$unsigned(in_error) + 1'b1) : $unsigned(in_error);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      e_r    <= in_error;
      v_r    <= in_velocity;
      emag_r <= emag_in;
    end
  end

  // integral with magnitude clamp, cleared outside the window
  always_comb begin
    ilim_s = $signed({2'b00, ilim_r});
    isum   = $signed({integ_r[Q_W-1], integ_r}) + $signed({e_r[Q_W-1], e_r});
    if (isum > ilim_s) begin
      iclamp = ilim_s;
    end else if (isum < -ilim_s) begin
      iclamp = -ilim_s;
    end else begin
      iclamp = isum;
    end
    integ_nxt = (emag_r < INTEG_WINDOW) ? iclamp[Q_W-1:0] : '0;
    deriv_nxt = have_prev_r ? ($signed({e_r[Q_W-1], e_r}) - $signed({prev_r[Q_W-1], prev_r}))
                            : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
    end else if (ctrl.integ_upd) begin
      integ_r     <= integ_nxt;
      prev_r      <= e_r;
      have_prev_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.integ_upd) begin
      deriv_r <= deriv_nxt;
    end
  end

  // shared multiplier
  always_comb begin
    unique case (ctrl.mul_sel)
      MUL_EP: begin
        op_a = $signed({e_r[Q_W-1], e_r});
        op_b = gp_r;
      end
      MUL_IG: begin
        op_a = $signed({integ_r[Q_W-1], integ_r});
        op_b = gi_r;
      end
      MUL_DG: begin
        op_a = deriv_r;
        op_b = gd_r;
      end
      MUL_ZM: begin
        op_a = $signed({1'b0, emag_r});
        op_b = $signed({1'b0, mo_r});
      end
      MUL_VG: begin
        op_a = $signed({v_r[Q_W-1], v_r});
        op_b = gv_r;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    prod_nxt = op_a * op_b;
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_sel != MUL_NONE) begin
      prod_r <= prod_nxt;
    end
  end

  // round to Q8.16, ties away from zero, then accumulate or clamp
  always_comb begin
    rsum     = prod_r + (prod_r[PROD_W-1] ? RND_DN : RND_UP);
    term     = rsum[PROD_W-1:RND_SH];
    term_ext = {{(ACC_W - TERM_W){term[TERM_W-1]}}, term};
    lim_ext  = $signed(ACC_W'(lim_r));
    acc_nxt  = acc_r;
    case (ctrl.acc_op)
      ACC_CLEAR: acc_nxt = '0;
      ACC_ADD:   acc_nxt = acc_r + term_ext;
      ACC_CLAMP: begin
        if (acc_r > lim_ext) begin
          acc_nxt = lim_ext;
        end else if (acc_r < -lim_ext) begin
          acc_nxt = -lim_ext;
        end
      end
      default: acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // restoring divider, one quotient bit per step; remainder starts below the divisor
  assign zone_off = (dz_r == '0) || (emag_r >= {1'b0, dz_r});
  assign div_more = (div_cnt_r != DIV_LAST);

  always_comb begin
    trial   = {rem_r, sh_r[MAG_W-1]};
    ge      = (trial >= {1'b0, dz_r});
    rem_nxt = ge ? MAG_W'(trial - {1'b0, dz_r}) : trial[MAG_W-1:0];
    sh_nxt  = {sh_r[MAG_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (ctrl.div_init) begin
      div_cnt_r <= '0;
    end else if (ctrl.div_step) begin
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.div_init) begin
      rem_r <= prod_r[DIV_BITS +: MAG_W];
      sh_r  <= prod_r[DIV_BITS-1:0];
    end else if (ctrl.div_step) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_nxt;
    end
  end

  // zone limit never drops below the floor
  always_ff @(posedge clk) begin
    if (ctrl.lim_floor) begin
      lim_r <= (sh_r < mina_r) ? mina_r : sh_r;
    end
  end

  always_comb begin
    mo_ext = $signed(ACC_W'(mo_r));
    if (acc_r > mo_ext) begin
      drive_val = $signed({1'b0, mo_r});
    end else if (acc_r < -mo_ext) begin
      drive_val = -$signed({1'b0, mo_r});
    end else begin
      drive_val = acc_r[Q_W-1:0];
    end
  end

endmodule

@@ sv/pid_with_decel_zone_limit_unit.sv @@
// PID position controller with deceleration-zone limit and velocity feedforward,
// signed Q8.16 throughout. One item (error, velocity) is taken at a time and gives one
// drive beat. A small control store steps a datapath with one shared 25x24 multiplier,
// a rounding accumulator and a one-bit-per-step divider. Inside the deceleration zone
// an item runs through the 23 divider steps and the zone clamp before its result is
// loaded; outside the zone, or with the zone disabled, both are skipped. The block
// returns to accept the next item in the cycle after the result is loaded; the output
// register lets that happen while the drive beat still waits to be taken. Configuration
// writes take effect at once and must only come while the block is idle.
module pid_with_decel_zone_limit_unit import pwdz_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  pwdz_in_if.sink              in_ch,
  pwdz_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [Q_W-1:0]       cfg_data
);

  ctrl_t ctrl;
  stat_t stat;

  logic                  in_acc;
  logic                  zone_off, div_more;
  logic signed [Q_W-1:0] dp_drive;
  logic                  out_busy, load_fire;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [Q_W-1:0] drive_r;
  logic                  item_busy_r;

  assign in_ch.ready = ctrl.in_rdy;
  assign in_acc      = in_ch.valid && ctrl.in_rdy;
  assign out_busy    = out_valid_r && !out_ch.ready;
  assign load_fire   = ctrl.out_load && !out_busy;

  always_comb begin
    stat.accept   = in_acc;
    stat.zone_off = zone_off;
    stat.div_more = div_more;
    stat.out_busy = out_busy;
  end

  pwdz_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  pwdz_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .in_acc      (in_acc),
    .in_error    (in_ch.error),
    .in_velocity (in_ch.velocity),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .zone_off    (zone_off),
    .div_more    (div_more),
    .drive_val   (dp_drive)
  );

  // output register: load on the final step, drop once the beat is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      item_busy_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        item_busy_r <= 1'b1;
      end else if (load_fire) begin
        item_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_fire) begin
      drive_r <= dp_drive;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.drive = drive_r;

  a_start_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ctrl.integ_upd)
    else $error("item did not start after accept");

  a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    load_fire |=> (out_ch.valid && out_ch.drive == $past(dp_drive)))
    else $error("loaded result not presented");

  a_no_accept_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !item_busy_r)
    else $error("accept while an item is in flight");

  a_load_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    load_fire |-> item_busy_r)
    else $error("result loaded without an item");

endmodule
